>>> sv/multi_talker_audio_mixer_assert.svh
// assertion macros for the talker mixer
// used by the top level only
`ifndef MULTI_TALKER_AUDIO_MIXER_ASSERT_SVH
`define MULTI_TALKER_AUDIO_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define MTM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MTM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MTM_ASSERT_IMP(label, clk, rst, a, c)
`define MTM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> sv/mtm_pkg.sv
// shared constants and types of the talker mixer
// no dependencies
`default_nettype none
package mtm_pkg;
  localparam int TALKERS = 16;
  localparam int BLOCK_SAMPLES = 320;
  localparam int SLOT_W = $clog2(TALKERS);
  localparam int IDX_W = 9;
  localparam int CNT_W = $clog2(TALKERS + 1);
  localparam int STORE_DEPTH = TALKERS * BLOCK_SAMPLES;
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_MIX = 2'd2;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_FILTERED = 3'd3;
  localparam logic [2:0] ST_FRAME = 3'd4;
  localparam logic [2:0] ST_SKIPPED = 3'd5;
  localparam logic [2:0] ST_MIXED = 3'd6;

  localparam logic [1:0] REG_LOCAL = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0] idx;
  } store_addr_t;
endpackage
`default_nettype wire

>>> sv/mtm_sample_ram.sv
// sample store: one write port, one registered read port
// depends on mtm_pkg
`default_nettype none
module mtm_sample_ram (
  input wire logic clk,
  input wire logic we,
  input wire logic [mtm_pkg::STORE_AW-1:0] waddr,
  input wire logic [15:0] wdata,
  input wire logic [mtm_pkg::STORE_AW-1:0] raddr,
  output logic [15:0] rdata
);
  import mtm_pkg::*;
  logic [15:0] mem [STORE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/multi_talker_audio_mixer.sv
// talker mixer top level: talker table, sequencer and mix accumulator
// depends on mtm_pkg, mtm_sample_ram and the assert header
//
// a frame or mix walks the table one entry a cycle, and latched last entries
// add the read and add tail; one request at a time, the next taken in the cycle
// the result leaves; reset clears the talker table, marks, latch and count at
// once; the sample memory is not cleared
`default_nettype none
`include "multi_talker_audio_mixer_assert.svh"
module multi_talker_audio_mixer (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [31:0] cfg_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] command,
  input wire logic [31:0] source_address,
  input wire logic [8:0] sample_index,
  input wire logic signed [15:0] sample_value,
  input wire logic [47:0] now_time,
  input wire logic transmitting,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] status,
  output logic [3:0] slot,
  output logic [4:0] active_count,
  output logic signed [15:0] mixed_sample
);
  import mtm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FRAME = 2'd1;
  localparam logic [1:0] S_MIX = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // configuration
  logic [31:0] local_address;
  logic [23:0] timeout_us;

  // talker table (flip-flops, one entry per talker)
  logic [31:0] taddr [TALKERS];
  logic [47:0] tseen [TALKERS];
  logic [TALKERS-1:0] audio_mark, mix_mask;
  logic [CNT_W-1:0] mix_count;

  logic [1:0] state;
  logic [SLOT_W:0] cnt;
  logic [SLOT_W-1:0] rd_slot;
  logic rd_en;
  logic acc_en;
  logic [IDX_W-1:0] idx_q;
  logic [47:0] now_q;
  logic signed [20:0] acc;
  logic [15:0] rdata;

  // result register
  logic res_full;
  assign out_valid = res_full;
  // take a request when idle and the result slot is free or leaving
  assign in_ready = (state == S_IDLE) && (!res_full || out_ready);
  wire take = in_valid && in_ready;

  // talker lookup, first match and first free entry
  logic hit, free_ok;
  logic [SLOT_W-1:0] hit_slot, free_slot;
  always_comb begin
    hit = 1'b0; free_ok = 1'b0; hit_slot = '0; free_slot = '0;
    for (int i = TALKERS - 1; i >= 0; i--) begin
      if (taddr[i] == source_address) begin
        hit = 1'b1; hit_slot = SLOT_W'(i);
      end
      if (taddr[i] == 32'd0) begin
        free_ok = 1'b1; free_slot = SLOT_W'(i);
      end
    end
  end

  wire filt = transmitting || source_address == local_address ||
              source_address == 32'd0 || sample_index >= IDX_W'(BLOCK_SAMPLES);
  wire [SLOT_W-1:0] use_slot = hit ? hit_slot : free_slot;
  wire store = take && command == CMD_SAMPLE && !filt && (hit || free_ok);
  wire last_smp = sample_index == IDX_W'(BLOCK_SAMPLES - 1);

  store_addr_t wa, ra;
  assign wa.slot = use_slot;
  assign wa.idx = sample_index;
  assign ra.slot = rd_slot;
  assign ra.idx = idx_q;
  wire [STORE_AW-1:0] waddr = STORE_AW'(wa.slot * BLOCK_SAMPLES) + STORE_AW'(wa.idx);
  wire [STORE_AW-1:0] raddr = STORE_AW'(ra.slot * BLOCK_SAMPLES) + STORE_AW'(ra.idx);

  mtm_sample_ram u_ram (
    .clk(clk), .we(store), .waddr(waddr), .wdata(sample_value),
    .raddr(raddr), .rdata(rdata)
  );

  // aging test for the entry under the frame walk
  wire [SLOT_W-1:0] fs = cnt[SLOT_W-1:0];
  wire [48:0] age = {1'b0, now_q} - {1'b0, tseen[fs]};
  wire stale = taddr[fs] != 32'd0 && !age[48] && age[47:0] > {24'd0, timeout_us};
  wire live = !stale && taddr[fs] != 32'd0 && audio_mark[fs];

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'd0;
      timeout_us <= 24'd100000;
      for (int i = 0; i < TALKERS; i++) begin
        taddr[i] <= 32'd0; tseen[i] <= 48'd0;
      end
      audio_mark <= '0; mix_mask <= '0; mix_count <= '0;
      state <= S_IDLE; res_full <= 1'b0; cnt <= '0; rd_en <= 1'b0; acc_en <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LOCAL) local_address <= cfg_data;
        else if (cfg_index == REG_TIMEOUT) timeout_us <= cfg_data[23:0];
      end
      if (out_valid && out_ready) res_full <= 1'b0;
      rd_en <= 1'b0;
      // memory data for an issued read is back in the cycle after the issue
      acc_en <= rd_en;
      case (state)
        S_IDLE: begin
          if (take) begin
            idx_q <= sample_index; now_q <= now_time;
            status <= ST_FILTERED; slot <= '0; mixed_sample <= '0;
            cnt <= '0; acc <= '0;
            if (command == CMD_SAMPLE) begin
              res_full <= 1'b1;
              if (!filt) begin
                if (hit || free_ok) begin
                  status <= hit ? ST_EXISTING : ST_NEW;
                  slot <= use_slot;
                  if (!hit) taddr[free_slot] <= source_address;
                  if (last_smp) begin
                    audio_mark[use_slot] <= 1'b1; tseen[use_slot] <= now_time;
                  end
                end else status <= ST_FULL;
              end
            end else if (command == CMD_FRAME) begin
              mix_count <= '0;
              if (transmitting) begin
                mix_mask <= '0; status <= ST_SKIPPED; res_full <= 1'b1;
              end else begin
                status <= ST_FRAME; state <= S_FRAME;
              end
            end else if (command == CMD_MIX) begin
              status <= ST_MIXED;
              if (sample_index >= IDX_W'(BLOCK_SAMPLES)) res_full <= 1'b1;
              else state <= S_MIX;
            end else res_full <= 1'b1;
          end
        end
        S_FRAME: begin
          if (stale) taddr[fs] <= 32'd0;
          mix_mask[fs] <= live;
          if (live) mix_count <= mix_count + CNT_W'(1);
          if (stale || live) audio_mark[fs] <= 1'b0;
          if (cnt == (SLOT_W+1)'(TALKERS - 1)) state <= S_DONE;
          cnt <= cnt + 1'b1;
        end
        S_MIX: begin
          // issue one read per cycle, accumulate once the registered memory data is back
          if (cnt < (SLOT_W+1)'(TALKERS)) begin
            rd_slot <= cnt[SLOT_W-1:0];
            rd_en <= mix_mask[cnt[SLOT_W-1:0]];
            cnt <= cnt + 1'b1;
          end
          if (acc_en) acc <= acc + 21'(signed'(rdata));
          if (cnt == (SLOT_W+1)'(TALKERS) && !rd_en && !acc_en) state <= S_DONE;
        end
        default: begin
          if (status == ST_MIXED)
            mixed_sample <= (acc > 21'sd32767) ? 16'sh7fff :
                            (acc < -21'sd32768) ? 16'sh8000 : acc[15:0];
          res_full <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign active_count = 5'(mix_count);

  `MTM_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `MTM_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `MTM_ASSERT_IMP(a_count, clk, rst, state == S_IDLE, mix_count == CNT_W'($countones(mix_mask)))
endmodule
`default_nettype wire
